// ----- hw/rtl/tsrc_pkg.sv -----
package tsrc_pkg;

  localparam int unsigned NUM_CFG = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COLLECT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINT_PERIOD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT     = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [15:0] COLLECT_PERIOD_RST = 16'd10;
  localparam logic [15:0] LOG_PERIOD_RST     = 16'd100;
  localparam logic [31:0] PRINT_PERIOD_RST   = 32'd1000;
  localparam logic [31:0] WRAP_LIMIT_RST     = 32'd10000;

  localparam logic [31:0] RATE_SCALE     = 32'd1000;
  localparam logic [31:0] RATE_SAT_LIMIT = 32'hFFFF_FFFF / RATE_SCALE;
  localparam logic [31:0] RATE_SAT_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [31:0] rtc_seconds;
  } in_t;

  typedef struct packed {
    logic        collect_due;
    logic        log_due;
    logic        print_due;
    logic        calibration_done;
    logic        calibrating;
    logic [31:0] calibrated_rate;
  } out_t;

endpackage

// ----- hw/rtl/tick_scheduler_with_rtc_calibration.sv -----
// Tick scheduler with RTC calibration. Every input transaction (a tick or a start-calibration
// command) yields one result transaction, which is registered into a two-entry output
// buffer that lets the block keep accepting while one result waits. Strobes come from
// per-period remainder counters that follow the tick count, so no divider sits in the tick
// path. After any configuration write the remainders are rebuilt by a bit-serial restoring
// remainder unit, one count bit per cycle, and in_ready stays low until the rebuild ends.
// Calibration measures ticks between two RTC second boundaries and reports 1000 times that
// count, saturated to 32 bits.
module tick_scheduler_with_rtc_calibration
  import tsrc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam int unsigned BIT_W = $clog2(COUNT_WIDTH);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COUNT_WIDTH - 1);

  logic [15:0] collect_period_r;
  logic [15:0] log_period_r;
  logic [31:0] print_period_r;
  logic [31:0] wrap_limit_r;

  logic [COUNT_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic                   cal_mode_r, cal_mode_nxt;
  logic [31:0]            measured_rate_r, measured_rate_nxt;
  logic [31:0]            start_seconds_r, start_seconds_nxt;
  logic [COUNT_WIDTH-1:0] first_tick_r, first_tick_nxt;
  logic                   seen_one_r, seen_one_nxt;

  logic [15:0] res_c_r, res_c_nxt;
  logic [15:0] res_l_r, res_l_nxt;
  logic [31:0] res_p_r, res_p_nxt;

  logic             busy_r;
  logic [BIT_W-1:0] bit_idx_r;

  out_t out_r, skid_r, result;
  logic out_valid_r, skid_valid_r;

  logic in_fire, out_fire;
  logic [COUNT_WIDTH-1:0] cnt1, diff;
  logic                   cnt_ovf;
  logic [15:0]            rc1, rl1;
  logic [31:0]            rp1;
  logic [31:0]            rtc_delta;
  logic [EXT_W-1:0]       diff_ext, cnt1_ext;
  logic [31:0]            rate_calc;
  logic                   clear_res;

  logic        div_bit;
  logic [16:0] trial_c, trial_l;
  logic [32:0] trial_p;

  assign in_ready  = !busy_r && !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    cnt1      = tick_count_r + COUNT_WIDTH'(1);
    cnt_ovf   = &tick_count_r;
    cnt1_ext  = EXT_W'(cnt1);
    diff      = cnt1 - first_tick_r;
    diff_ext  = EXT_W'(diff);
    rate_calc = (diff_ext > EXT_W'(RATE_SAT_LIMIT)) ? RATE_SAT_VALUE
                                                    : 32'(diff_ext) * RATE_SCALE;
    rtc_delta = in_data.rtc_seconds - start_seconds_r;

    rc1 = (cnt_ovf || collect_period_r == 16'd0 || (res_c_r + 16'd1) == collect_period_r)
          ? 16'd0 : res_c_r + 16'd1;
    rl1 = (cnt_ovf || log_period_r == 16'd0 || (res_l_r + 16'd1) == log_period_r)
          ? 16'd0 : res_l_r + 16'd1;
    rp1 = (cnt_ovf || print_period_r == 32'd0 || (res_p_r + 32'd1) == print_period_r)
          ? 32'd0 : res_p_r + 32'd1;

    tick_count_nxt    = tick_count_r;
    cal_mode_nxt      = cal_mode_r;
    measured_rate_nxt = measured_rate_r;
    start_seconds_nxt = start_seconds_r;
    first_tick_nxt    = first_tick_r;
    seen_one_nxt      = seen_one_r;
    res_c_nxt         = res_c_r;
    res_l_nxt         = res_l_r;
    res_p_nxt         = res_p_r;
    clear_res         = 1'b0;
    result            = '0;

    if (in_data.opcode == OP_START) begin
      tick_count_nxt    = '0;
      cal_mode_nxt      = 1'b1;
      measured_rate_nxt = '0;
      start_seconds_nxt = in_data.rtc_seconds;
      first_tick_nxt    = '0;
      seen_one_nxt      = 1'b0;
      clear_res         = 1'b1;
    end else begin
      tick_count_nxt = cnt1;
      res_c_nxt      = rc1;
      res_l_nxt      = rl1;
      res_p_nxt      = rp1;
      if (cal_mode_r) begin
        if (rtc_delta > {31'd0, seen_one_r}) begin
          if (!seen_one_r) begin
            seen_one_nxt   = 1'b1;
            first_tick_nxt = cnt1;
          end else begin
            seen_one_nxt            = 1'b0;
            measured_rate_nxt       = rate_calc;
            tick_count_nxt          = '0;
            cal_mode_nxt            = 1'b0;
            clear_res               = 1'b1;
            result.calibration_done = 1'b1;
          end
        end
      end else begin
        result.collect_due = (collect_period_r != 16'd0) && (rc1 == 16'd0);
        result.log_due     = (log_period_r != 16'd0) && (rl1 == 16'd0);
        result.print_due   = (print_period_r != 32'd0) && (rp1 == 32'd0);
        if (cnt1_ext >= EXT_W'(wrap_limit_r)) begin
          tick_count_nxt = '0;
          clear_res      = 1'b1;
        end
      end
    end

    if (clear_res) begin
      res_c_nxt = '0;
      res_l_nxt = '0;
      res_p_nxt = '0;
    end

    result.calibrating     = cal_mode_nxt;
    result.calibrated_rate = measured_rate_nxt;
  end

  always_comb begin
    div_bit = tick_count_r[bit_idx_r];
    trial_c = {res_c_r, div_bit};
    trial_l = {res_l_r, div_bit};
    trial_p = {res_p_r, div_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collect_period_r <= COLLECT_PERIOD_RST;
      log_period_r     <= LOG_PERIOD_RST;
      print_period_r   <= PRINT_PERIOD_RST;
      wrap_limit_r     <= WRAP_LIMIT_RST;
      tick_count_r     <= '0;
      cal_mode_r       <= 1'b0;
      measured_rate_r  <= '0;
      start_seconds_r  <= '0;
      first_tick_r     <= '0;
      seen_one_r       <= 1'b0;
      res_c_r          <= '0;
      res_l_r          <= '0;
      res_p_r          <= '0;
      busy_r           <= 1'b0;
      bit_idx_r        <= '0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLLECT_PERIOD: collect_period_r <= cfg_wdata[15:0];
          CFG_LOG_PERIOD:     log_period_r     <= cfg_wdata[15:0];
          CFG_PRINT_PERIOD:   print_period_r   <= cfg_wdata;
          CFG_WRAP_LIMIT:     wrap_limit_r     <= cfg_wdata;
          default: ;
        endcase
        busy_r    <= 1'b1;
        bit_idx_r <= BIT_LAST;
        res_c_r   <= '0;
        res_l_r   <= '0;
        res_p_r   <= '0;
      end else if (busy_r) begin
        res_c_r <= (trial_c >= {1'b0, collect_period_r}) ? 16'(trial_c - {1'b0, collect_period_r})
                                                         : trial_c[15:0];
        res_l_r <= (trial_l >= {1'b0, log_period_r}) ? 16'(trial_l - {1'b0, log_period_r})
                                                     : trial_l[15:0];
        res_p_r <= (trial_p >= {1'b0, print_period_r}) ? 32'(trial_p - {1'b0, print_period_r})
                                                       : trial_p[31:0];
        if (bit_idx_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          bit_idx_r <= bit_idx_r - BIT_W'(1);
        end
      end else if (in_fire) begin
        tick_count_r    <= tick_count_nxt;
        cal_mode_r      <= cal_mode_nxt;
        measured_rate_r <= measured_rate_nxt;
        start_seconds_r <= start_seconds_nxt;
        first_tick_r    <= first_tick_nxt;
        seen_one_r      <= seen_one_nxt;
        res_c_r         <= res_c_nxt;
        res_l_r         <= res_l_nxt;
        res_p_r         <= res_p_nxt;
      end

      if (in_fire) begin
        if (out_valid_r && !out_ready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= result;
      end else begin
        out_r <= result;
      end
    end else if (out_fire && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid entry is held while the output register is empty.");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready)
    else $error("Input is accepted while remainders are being rebuilt.");

  a_start_enters_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.opcode == OP_START) |=> cal_mode_r && tick_count_r == '0)
    else $error("Start command did not enter calibration with a cleared count.");

  a_collect_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !cfg_we && collect_period_r != 16'd0) |-> res_c_r < collect_period_r)
    else $error("Collect remainder is not below its period.");

  a_print_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !cfg_we && print_period_r != 32'd0) |-> res_p_r < print_period_r)
    else $error("Print remainder is not below its period.");
`endif

endmodule
